// ===== design/slrg_pkg.sv =====
// Shared constants and types for the shuffled Lehmer random generator.
`default_nettype none
package slrg_pkg;

    localparam int unsigned VAL_W    = 31;
    localparam int unsigned PROD_W   = 46;
    localparam int unsigned MUL_A_W  = 15;

    localparam logic [MUL_A_W-1:0] LEH_A   = 15'd16807;
    localparam logic [VAL_W:0]     LEH_M   = 32'd2147483647;
    localparam int unsigned        WARMUP_STEPS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_RED,
        ST_SWAP
    } state_t;

endpackage
`default_nettype wire

// ===== design/slrg_modmul.sv =====
// Shared multiply-by-16807 modulo 2^31-1 unit: registered product, folded reduction.
`default_nettype none
module slrg_modmul (
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic [slrg_pkg::VAL_W-1:0] x_in,
    output logic      [slrg_pkg::VAL_W-1:0] x_out
);

    logic [slrg_pkg::PROD_W-1:0] prod_reg;
    logic [slrg_pkg::VAL_W:0]    fold_sum;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= slrg_pkg::PROD_W'(x_in) * slrg_pkg::PROD_W'(slrg_pkg::LEH_A);
        end
    end

    // 2^31 == 1 mod M, so high part adds onto low part; one correction suffices
    always_comb begin
        fold_sum = (slrg_pkg::VAL_W+1)'(prod_reg[slrg_pkg::PROD_W-1:slrg_pkg::VAL_W])
                 + (slrg_pkg::VAL_W+1)'(prod_reg[slrg_pkg::VAL_W-1:0]);
        if (fold_sum >= slrg_pkg::LEH_M) begin
            fold_sum = fold_sum - slrg_pkg::LEH_M;
        end
        x_out = fold_sum[slrg_pkg::VAL_W-1:0];
    end

endmodule
`default_nettype wire

// ===== design/slrg_pick_div.sv =====
// Pick index: previous pick divided by the bucket width through a registered reciprocal multiply.
`default_nettype none
module slrg_pick_div #(
    parameter int unsigned TABLE_SIZE = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          start,
    input  wire logic [slrg_pkg::VAL_W-1:0]    dividend,
    output logic [$clog2(TABLE_SIZE)-1:0]      idx
);

    localparam longint unsigned NDIV    = 64'd1
                                        + ((64'(slrg_pkg::LEH_M) - 64'd1) / 64'(TABLE_SIZE));
    localparam int unsigned     SHIFT   = slrg_pkg::VAL_W + $clog2(NDIV);
    localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + NDIV - 64'd1) / NDIV;
    localparam int unsigned     RECIP_W = slrg_pkg::VAL_W + 1;
    localparam int unsigned     PROD_W  = slrg_pkg::VAL_W + RECIP_W;
    localparam int unsigned     Q_W     = $clog2(TABLE_SIZE + 1);
    localparam int unsigned     IDX_W   = $clog2(TABLE_SIZE);

    logic [PROD_W-1:0] prod_reg;
    logic [Q_W-1:0]    quot;

    // ceiling reciprocal with VAL_W extra fraction bits: exact for every 31-bit dividend
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= PROD_W'(dividend) * PROD_W'(RECIP);
        end
    end

    assign quot = Q_W'(prod_reg >> SHIFT);
    assign idx  = (quot >= Q_W'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1) : quot[IDX_W-1:0];

endmodule
`default_nettype wire

// ===== design/slrg_table.sv =====
// Shuffle table memory: one write port, one registered read port.
`default_nettype none
module slrg_table #(
    parameter int unsigned TABLE_SIZE = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
    input  wire logic [slrg_pkg::VAL_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
    output logic      [slrg_pkg::VAL_W-1:0]    rd_data
);

    logic [slrg_pkg::VAL_W-1:0] mem [TABLE_SIZE];
    logic [slrg_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/shuffled_lehmer_random_generator.sv =====
// Shuffled Lehmer generator top level: sequencer around the shared modular multiplier.
// A draw steps through index, multiply, reduce and swap before its result word is registered.
// Seeding (action 1, or first draw after reset) first runs the warm-up steps and one step per table entry.
// Each generator step passes the multiply and reduce states of the single multiply/reduce unit.
// One word in flight; input reopens once the result is registered, swap waits on a held result.
// Synchronous active-low reset: generator 1, pick 0, table unprimed; table contents undefined.
`default_nettype none
module shuffled_lehmer_random_generator #(
    parameter int unsigned TABLE_SIZE = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [30:0] random_value, [31] zero
);

    localparam int unsigned VAL_W   = slrg_pkg::VAL_W;
    localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
    localparam int unsigned STEPS   = slrg_pkg::WARMUP_STEPS + TABLE_SIZE;
    localparam int unsigned STEP_W  = $clog2(STEPS);

    slrg_pkg::state_t   state_reg, state_next;
    logic [VAL_W-1:0]   x_reg, x_next;
    logic [VAL_W-1:0]   pick_reg, pick_next;
    logic [VAL_W-1:0]   out_reg, out_next;
    logic               primed_reg, primed_next;
    logic               seeding_reg, seeding_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    logic               mm_load;
    logic [VAL_W-1:0]   mm_out;
    logic               div_start;
    logic [VAL_W-1:0]   div_dividend;
    logic [IDX_W-1:0]   div_idx;
    logic               tbl_wr_en;
    logic [IDX_W-1:0]   tbl_wr_addr;
    logic [VAL_W-1:0]   tbl_wr_data;
    logic               tbl_rd_en;
    logic [VAL_W-1:0]   tbl_rd_data;
    logic [VAL_W-1:0]   seed_sel;
    logic               accept;

    slrg_modmul u_modmul (
        .aclk  (aclk),
        .load  (mm_load),
        .x_in  (x_reg),
        .x_out (mm_out)
    );

    slrg_pick_div #(.TABLE_SIZE(TABLE_SIZE)) u_pick_div (
        .aclk     (aclk),
        .start    (div_start),
        .dividend (div_dividend),
        .idx      (div_idx)
    );

    slrg_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (div_idx),
        .rd_data (tbl_rd_data)
    );

    assign s_tready = (state_reg == slrg_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= slrg_pkg::ST_IDLE;
            x_reg         <= VAL_W'(1);
            pick_reg      <= '0;
            primed_reg    <= 1'b0;
            seeding_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            pick_reg      <= pick_next;
            primed_reg    <= primed_next;
            seeding_reg   <= seeding_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        pick_next      = pick_reg;
        out_next       = out_reg;
        primed_next    = primed_reg;
        seeding_next   = seeding_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mm_load        = 1'b0;
        div_start      = 1'b0;
        div_dividend   = pick_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = div_idx;
        tbl_wr_data    = x_reg;
        tbl_rd_en      = 1'b0;
        seed_sel       = s_tuser[0] ? s_tdata[VAL_W-1:0] : x_reg;

        case (state_reg)
            slrg_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] || !primed_reg) begin
                        x_next       = (seed_sel == '0) ? VAL_W'(1) : seed_sel;
                        seeding_next = 1'b1;
                        step_next    = '0;
                        state_next   = slrg_pkg::ST_MUL;
                    end else begin
                        div_start  = 1'b1;
                        state_next = slrg_pkg::ST_DIV;
                    end
                end
            end
            slrg_pkg::ST_DIV: begin
                state_next = slrg_pkg::ST_MUL;
            end
            slrg_pkg::ST_MUL: begin
                mm_load    = 1'b1;
                state_next = slrg_pkg::ST_RED;
            end
            slrg_pkg::ST_RED: begin
                x_next = mm_out;
                if (seeding_reg) begin
                    // fill from the last entry down to entry 0 after warm-up
                    tbl_wr_en   = (step_reg >= STEP_W'(slrg_pkg::WARMUP_STEPS));
                    tbl_wr_addr = IDX_W'(STEPS - 1 - 32'(step_reg));
                    tbl_wr_data = mm_out;
                    step_next   = step_reg + 1'b1;
                    state_next  = slrg_pkg::ST_MUL;
                    if (step_reg == STEP_W'(STEPS - 1)) begin
                        pick_next    = mm_out;
                        primed_next  = 1'b1;
                        seeding_next = 1'b0;
                        div_start    = 1'b1;
                        div_dividend = mm_out;
                        state_next   = slrg_pkg::ST_DIV;
                    end
                end else begin
                    tbl_rd_en  = 1'b1;
                    state_next = slrg_pkg::ST_SWAP;
                end
            end
            slrg_pkg::ST_SWAP: begin
                if (!out_valid_reg || m_tready) begin
                    tbl_wr_en      = 1'b1;
                    pick_next      = tbl_rd_data;
                    out_next       = tbl_rd_data;
                    out_valid_next = 1'b1;
                    state_next     = slrg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = slrg_pkg::ST_IDLE;
            end
        endcase
    end

    a_primed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");

    a_result_from_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == slrg_pkg::ST_SWAP))
        else $error("result word raised outside the swap step");

    a_draw_needs_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slrg_pkg::ST_RED && !seeding_reg) |-> primed_reg)
        else $error("table read before it was filled");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    a_seed_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slrg_pkg::ST_DIV && $past(state_reg) == slrg_pkg::ST_RED)
        |-> ($past(step_reg) == STEP_W'(STEPS - 1)))
        else $error("seeding ended at wrong step count");

endmodule
`default_nettype wire

// ===== sim/shuffled_lehmer_random_generator_tb.sv =====
// Testbench for the shuffled Lehmer random generator: directed and random words checked against a predictor.
`timescale 1ns / 100ps

typedef enum bit {
    ACT_DRAW   = 1'b0,
    ACT_RESEED = 1'b1
} draw_action_e;

class draw_scoreboard #(int unsigned ENTRIES = 32);
    bit [30:0] gen_value;
    bit [30:0] shuffle[ENTRIES];
    bit [30:0] pick;
    bit        primed;
    bit [30:0] expected_values[$];
    int        mismatches;

    function new();
        gen_value  = 31'd1;
        pick       = '0;
        primed     = 1'b0;
        mismatches = 0;
        foreach (shuffle[i]) shuffle[i] = '0;
    endfunction

    function bit [30:0] lehmer_step(bit [30:0] x);
        bit [63:0] prod;
        prod = 64'(x) * 64'(slrg_pkg::LEH_A);
        return 31'(prod % 64'(slrg_pkg::LEH_M));
    endfunction

    function void refill(bit [30:0] seed);
        bit [30:0] x;
        x = (seed == '0) ? 31'd1 : seed;
        repeat (slrg_pkg::WARMUP_STEPS) x = lehmer_step(x);
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            x = lehmer_step(x);
            shuffle[i] = x;
        end
        gen_value = x;
        pick      = shuffle[0];
        primed    = 1'b1;
    endfunction

    function void note_request(draw_action_e act, bit [30:0] seed);
        bit [63:0] span;
        bit [63:0] slot;
        span = 64'd1 + (64'(slrg_pkg::LEH_M) - 64'd1) / 64'(ENTRIES);
        if (act == ACT_RESEED) begin
            refill(seed);
        end else if (!primed) begin
            refill(gen_value);
        end
        gen_value = lehmer_step(gen_value);
        slot = 64'(pick) / span;
        if (slot >= 64'(ENTRIES)) slot = 64'(ENTRIES - 1);
        pick = shuffle[slot];
        shuffle[slot] = gen_value;
        expected_values.push_back(pick);
    endfunction

    task report_mismatch(string what, bit [30:0] got, bit [30:0] want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task check_value(bit [30:0] got);
        bit [30:0] want;
        if (expected_values.size() == 0) begin
            report_mismatch("unexpected word", got, '0);
        end else begin
            want = expected_values.pop_front();
            if (got != want) report_mismatch("random_value", got, want);
        end
    endtask

    task flush_check();
        while (expected_values.size() != 0) begin
            report_mismatch("missing word", '0, expected_values.pop_front());
        end
    endtask
endclass

module shuffled_lehmer_random_generator_tb;
    localparam int unsigned ENTRIES       = 32;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned SETTLE_CYCLES = 150;
    localparam int unsigned PHASE_WORDS   = 470;
    localparam bit [30:0]   SEED_ONES     = '1;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    int send_idle_pct;
    int recv_stall_pct;
    int holds_requested;
    int holds_done;
    int quiet_cycles;

    draw_scoreboard #(ENTRIES) sb;

    shuffled_lehmer_random_generator #(
        .TABLE_SIZE(ENTRIES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin : receiver
        m_tready   = 1'b0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (holds_done != holds_requested) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_request(draw_action_e'(s_tuser[0]), s_tdata[30:0]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_value(m_tdata[30:0]);
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("** shuffled_lehmer_random_generator: FAILED **");
        $finish;
    end

    task automatic send_word(draw_action_e act, bit [30:0] seed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {1'b0, 31'($urandom)};
            s_tuser  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, seed};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_values.size() != 0) @(posedge aclk);
    endtask

    function automatic bit [30:0] random_seed();
        case ($urandom_range(9))
            0:       return 31'($urandom_range(15));
            1:       return SEED_ONES - 31'($urandom_range(15));
            2:       return 31'd1 << $urandom_range(30);
            3:       return ~(31'd1 << $urandom_range(30));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic random_phase(int words, bit with_hold);
        draw_action_e act;
        for (int n = 0; n < words; n++) begin
            if (with_hold && n == words / 4) holds_requested++;
            act = ($urandom_range(99) < 8) ? ACT_RESEED : ACT_DRAW;
            send_word(act, random_seed());
        end
    endtask

    initial begin : stimulus
        sb              = new();
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        holds_requested = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first draw seeds itself; seed field is ignored on draws
        send_word(ACT_DRAW, SEED_ONES);
        send_word(ACT_DRAW, '0);
        send_word(ACT_DRAW, 31'h2AAA_AAAA);
        // zero seed behaves as one
        send_word(ACT_RESEED, '0);
        send_word(ACT_DRAW, '0);
        send_word(ACT_RESEED, 31'd1);
        send_word(ACT_DRAW, 31'h5555_5555);
        send_word(ACT_RESEED, SEED_ONES - 31'd1);
        send_word(ACT_DRAW, '0);
        send_word(ACT_DRAW, '0);
        // all-ones seed equals the modulus: generator sticks at zero
        send_word(ACT_RESEED, SEED_ONES);
        send_word(ACT_DRAW, '0);
        send_word(ACT_DRAW, '0);
        send_word(ACT_DRAW, '0);
        send_word(ACT_RESEED, 31'h5555_5555);
        send_word(ACT_DRAW, '0);
        send_word(ACT_RESEED, 31'h2AAA_AAAA);
        send_word(ACT_DRAW, SEED_ONES);
        send_word(ACT_RESEED, 31'd12345);
        for (int k = 0; k < 5; k++) send_word(ACT_DRAW, 31'($urandom));
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            random_phase(PHASE_WORDS, phase == 0);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.flush_check();
        if (sb.mismatches == 0) begin
            $display("** shuffled_lehmer_random_generator: PASSED **");
        end else begin
            $display("** shuffled_lehmer_random_generator: FAILED **");
        end
        $finish;
    end
endmodule
